### src/qclt_pkg.sv
// types and constants shared by the command line tokenizer
// no dependencies; compiled first
`default_nettype none

package qclt_pkg;

    localparam int MAX_TOKENS  = 255;
    localparam logic [7:0] TOKEN_CAP = 8'((MAX_TOKENS > 255) ? 255 : MAX_TOKENS);

    // at most three results come from one input item
    localparam int MAX_RESULTS = 3;
    localparam int RES_DEPTH   = 8;
    localparam int RES_AW      = $clog2(RES_DEPTH);
    localparam int RES_CW      = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_DISCARD = 2'd2,
        KIND_LINE    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
        logic       empty_line;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] token_byte;
        logic [7:0] token_total;
        logic       line_valid;
        logic       last_of_run;
    } out_item_t;

    // results of one input item, handed to the result queue
    typedef struct packed {
        logic [1:0]           count;
        out_item_t [MAX_RESULTS-1:0] item;
    } push_t;

endpackage

`default_nettype wire

### src/qclt_if.sv
// valid/ready channels for line bytes and token results
// depends on qclt_pkg
`default_nettype none

interface qclt_line_if;
    import qclt_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface qclt_token_if;
    import qclt_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/qclt_core.sv
// input register, tokenizer state and the per-byte decode logic
// depends on qclt_pkg and qclt_if
`default_nettype none

module qclt_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    qclt_line_if.sink          line_chan,
    input  wire logic          room,
    output logic               push_en,
    output qclt_pkg::push_t    push
);
    import qclt_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v < TOKEN_CAP) ? v + 8'd1 : v;
    endfunction

    in_item_t   stage_reg;
    logic       stage_valid_reg;
    logic       in_quotes_reg, in_quotes_next;
    logic       prev_bsl_reg, prev_bsl_next;
    logic       token_open_reg, token_open_next;
    logic [7:0] counted_reg, counted_next;
    logic [7:0] emitted_reg, emitted_next;
    logic       skip_reg, skip_next;
    logic       process;

    assign process        = stage_valid_reg && room;
    assign line_chan.ready = !stage_valid_reg || process;
    assign push_en        = process;

    always_comb
    begin
        logic [7:0] c;
        logic       split;
        logic       stop;
        logic       quote;
        logic       drop;
        logic       fin;
        logic [1:0] n;

        c    = stage_reg.text_byte;
        fin  = stage_reg.empty_line || stage_reg.final_byte;
        n    = 2'd0;
        push = '0;
        split = (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_COLON) ||
                (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LBRC) ||
                (c == CH_RBRC) || (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_EQ);
        stop  = (c == CH_CR) || (c == CH_LF) || (c == CH_SEMI) || (c == CH_NUL);
        quote = (c == CH_QUOTE) && !prev_bsl_reg;
        drop  = 1'b0;

        in_quotes_next  = in_quotes_reg;
        prev_bsl_next   = prev_bsl_reg;
        token_open_next = token_open_reg;
        counted_next    = counted_reg;
        emitted_next    = emitted_reg;
        skip_next       = skip_reg;

        if (!stage_reg.empty_line && !skip_reg)
        begin
            if (!in_quotes_reg && (c == CH_HASH))
            begin
                // comment ends the token, counted in the total but not for validity
                if (token_open_reg)
                begin
                    push.item[n].kind = KIND_END;
                    n = n + 2'd1;
                    emitted_next = sat_inc(emitted_reg);
                end
                token_open_next = 1'b0;
                skip_next       = 1'b1;
            end
            else
            begin
                in_quotes_next = in_quotes_reg ^ quote;
                if (!in_quotes_next && (split || stop || stage_reg.final_byte))
                begin
                    // final plain byte is always appended, whatever its value
                    if (stage_reg.final_byte && !stop && !split && !quote)
                    begin
                        push.item[n].kind       = KIND_BYTE;
                        push.item[n].token_byte = c;
                        n = n + 2'd1;
                        token_open_next = 1'b1;
                    end
                    if (token_open_next)
                    begin
                        push.item[n].kind = KIND_END;
                        n = n + 2'd1;
                        counted_next    = sat_inc(counted_reg);
                        emitted_next    = sat_inc(emitted_reg);
                        token_open_next = 1'b0;
                    end
                    if (stop)
                        skip_next = 1'b1;
                end
                else if ((c >= CH_SPACE) && (c <= CH_DEL))
                begin
                    drop = ((counted_reg == 8'd0) && (c == CH_EQ)) || quote ||
                           ((c == CH_BSL) && !in_quotes_next);
                    if (!drop)
                    begin
                        push.item[n].kind       = KIND_BYTE;
                        push.item[n].token_byte = c;
                        n = n + 2'd1;
                        token_open_next = 1'b1;
                    end
                end
                prev_bsl_next = (c == CH_BSL);
            end
        end

        if (fin)
        begin
            if (token_open_next)
            begin
                push.item[n].kind = KIND_DISCARD;
                n = n + 2'd1;
            end
            push.item[n].kind        = KIND_LINE;
            push.item[n].token_total = emitted_next;
            push.item[n].line_valid  = (counted_next != 8'd0);
            n = n + 2'd1;
            in_quotes_next  = 1'b0;
            prev_bsl_next   = 1'b0;
            token_open_next = 1'b0;
            counted_next    = 8'd0;
            emitted_next    = 8'd0;
            skip_next       = 1'b0;
        end

        if (n != 2'd0)
            push.item[n - 2'd1].last_of_run = 1'b1;
        push.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            in_quotes_reg   <= 1'b0;
            prev_bsl_reg    <= 1'b0;
            token_open_reg  <= 1'b0;
            counted_reg     <= 8'd0;
            emitted_reg     <= 8'd0;
            skip_reg        <= 1'b0;
        end
        else
        begin
            if (line_chan.ready)
                stage_valid_reg <= line_chan.valid;
            if (process)
            begin
                in_quotes_reg  <= in_quotes_next;
                prev_bsl_reg   <= prev_bsl_next;
                token_open_reg <= token_open_next;
                counted_reg    <= counted_next;
                emitted_reg    <= emitted_next;
                skip_reg       <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_chan.valid && line_chan.ready)
            stage_reg <= line_chan.payload;
    end

    // a line end item always closes with a line end result
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        process && (stage_reg.empty_line || stage_reg.final_byte) |->
        push.count != 2'd0 && push.item[push.count - 2'd1].kind == KIND_LINE)
        else $error("line end result missing");

    // line state is cleared after a line end
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        process && (stage_reg.empty_line || stage_reg.final_byte) |=>
        !in_quotes_reg && !token_open_reg && !skip_reg && emitted_reg == 8'd0)
        else $error("line state not cleared");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        counted_reg <= emitted_reg)
        else $error("counted tokens exceed emitted tokens");

    // a stop or a comment outside quotes always closes the pending token
    a_skip_closed: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> !token_open_reg)
        else $error("token open while skipping");

endmodule

`default_nettype wire

### src/qclt_result_fifo.sv
// result queue: takes up to three results per cycle, hands out one per transfer
// depends on qclt_pkg and qclt_if
`default_nettype none

module qclt_result_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_en,
    input  wire qclt_pkg::push_t push,
    output logic               room,
    qclt_token_if.source       token_chan
);
    import qclt_pkg::*;

    out_item_t         mem [RES_DEPTH];
    logic [RES_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CW-1:0] count_reg, count_next;
    logic              pop;
    logic [RES_CW-1:0] push_n;

    assign room               = count_reg <= RES_CW'(RES_DEPTH - MAX_RESULTS);
    assign token_chan.valid   = count_reg != '0;
    assign token_chan.payload = mem[rd_ptr_reg];
    assign pop                = token_chan.valid && token_chan.ready;
    assign push_n             = push_en ? RES_CW'(push.count) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + RES_AW'(pop);
        count_next  = count_reg + push_n - RES_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (push_en && (i < int'(push.count)))
                mem[wr_ptr_reg + RES_AW'(i)] <= push.item[i];
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CW'(RES_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> room)
        else $error("push without room");

    // queue level follows pushes and transfers
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + $past(push_n) - RES_CW'($past(pop)))
        else $error("queue level mismatch");

endmodule

`default_nettype wire

### src/quoted_command_line_tokenizer.sv
// Quoted command line tokenizer, top level.
// line_chan carries one byte of a command line per transfer, with final_byte on
// the last byte; an item with empty_line set ends a line without a byte.
// token_chan carries the results: token bytes, token end, token discard and a
// line end that reports the token total and whether a command token was seen.
// last_of_run marks the final result caused by one input item.
// One input byte is taken per cycle while the result queue has room. A byte passes
// the input register and the decode logic and is written into the result queue,
// from which its first result is offered. One item gives zero to three results;
// the output moves one result per cycle while the receiver is ready, so items
// that give more than one result set the sustained rate, bounded by the output
// side at one result a cycle. The result queue holds eight results and input is
// held off while fewer than three places are free, so a stalled receiver fills
// the queue and then stops input without losing anything.
// Reset clears all line state and empties the queue; no clearing pass.
// depends on qclt_pkg, qclt_if, qclt_core and qclt_result_fifo
`default_nettype none

module quoted_command_line_tokenizer (
    input  wire logic      clk,
    input  wire logic      rst_n,
    qclt_line_if.sink      line_chan,
    qclt_token_if.source   token_chan
);
    import qclt_pkg::*;

    logic  room;
    logic  push_en;
    push_t push;

    qclt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_chan (line_chan),
        .room      (room),
        .push_en   (push_en),
        .push      (push)
    );

    qclt_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (push_en),
        .push       (push),
        .room       (room),
        .token_chan (token_chan)
    );

endmodule

`default_nettype wire
